>>> hdl/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

    localparam int WAYS     = 4;
    localparam int SETS     = 64;
    localparam int AGE_BITS = 16;

    localparam int ADDR_BITS  = 32;
    localparam int INDEX_BITS = $clog2(SETS);
    localparam int SET_W      = (INDEX_BITS > 0) ? INDEX_BITS : 1;
    localparam int TAG_BITS   = ADDR_BITS - INDEX_BITS;
    localparam int WAY_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAY_OUT_W  = 2;

    // one row of the tag store holds every way of a set
    typedef struct packed {
        logic [WAYS-1:0][TAG_BITS-1:0] tags;
        logic [WAYS-1:0][AGE_BITS-1:0] ages;
    } t_row;

    // commands from the controller to the datapath
    typedef struct packed {
        logic lookup;   // capture address, read the set row
        logic update;   // write back the set row, load the result
    } t_cmd;

endpackage

`default_nettype wire

>>> hdl/sacl_ctrl.sv
`default_nettype none

module sacl_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output sacl_pkg::t_cmd   o_cmd
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   can_finish;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

    // the result slot is free, or its word leaves this cycle
    assign can_finish = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd.lookup = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.update = (r_state == ST_LOOKUP) && can_finish;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_LOOKUP;
                    end
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                ST_LOOKUP: begin
                    if (can_finish) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_lookup_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.lookup |=> (r_state == ST_LOOKUP))
        else $error("lookup did not move to the compare cycle");

    a_update_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |=> (r_out_valid && r_state == ST_IDLE))
        else $error("update did not present a result");

    a_free_slot_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOKUP && !r_out_valid) |-> o_cmd.update)
        else $error("compare cycle stalled with a free result slot");

endmodule

`default_nettype wire

>>> hdl/sacl_dpath.sv
`default_nettype none

module sacl_dpath (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  sacl_pkg::t_cmd                         i_cmd,
    input  wire  [sacl_pkg::ADDR_BITS-1:0]         i_address,
    output logic                                   o_is_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]         o_way_used
);

    sacl_pkg::t_row                                 r_mem [sacl_pkg::SETS];
    sacl_pkg::t_row                                 r_rd;
    logic [sacl_pkg::SETS-1:0][sacl_pkg::WAYS-1:0]  r_valid;
    logic [sacl_pkg::SET_W-1:0]                     r_set;
    logic [sacl_pkg::TAG_BITS-1:0]                  r_tag;
    logic                                           r_is_hit;
    logic [sacl_pkg::WAY_OUT_W-1:0]                 r_way_used;

    logic [sacl_pkg::SET_W-1:0]    in_set;
    logic [sacl_pkg::WAYS-1:0]     cur_valid;
    logic [sacl_pkg::WAYS-1:0]     hit_vec;
    logic                          hit;
    logic [sacl_pkg::WAY_W-1:0]    hit_way;
    logic                          inv_found;
    logic [sacl_pkg::WAY_W-1:0]    inv_way;
    logic [sacl_pkg::WAY_W-1:0]    old_way;
    logic [sacl_pkg::AGE_BITS-1:0] best_age;
    logic [sacl_pkg::WAY_W-1:0]    fill_way;
    logic [sacl_pkg::WAYS-1:0]     fill_mask;
    sacl_pkg::t_row                n_row;
    logic [sacl_pkg::WAY_W+1:0]    way_ext;

    localparam logic [sacl_pkg::AGE_BITS-1:0] AgeMax = {sacl_pkg::AGE_BITS{1'b1}};

    assign in_set = sacl_pkg::SET_W'(i_address
                    & sacl_pkg::ADDR_BITS'(sacl_pkg::SETS - 1));

    assign cur_valid = r_valid[r_set];

    always_comb begin
        hit_vec = '0;
        hit     = 1'b0;
        hit_way = '0;
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
            hit_vec[w] = cur_valid[w] && (r_rd.tags[w] == r_tag);
            if (hit_vec[w] && !hit) begin
                hit     = 1'b1;
                hit_way = sacl_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
            if (!cur_valid[w] && !inv_found) begin
                inv_found = 1'b1;
                inv_way   = sacl_pkg::WAY_W'(w);
            end
        end
    end

    // oldest way, ties to the lowest
    always_comb begin
        old_way  = '0;
        best_age = r_rd.ages[0];
        for (int w = 1; w < sacl_pkg::WAYS; w++) begin
            if (r_rd.ages[w] > best_age) begin
                best_age = r_rd.ages[w];
                old_way  = sacl_pkg::WAY_W'(w);
            end
        end
    end

    always_comb begin
        priority if (hit) begin
            fill_way = hit_way;
        end else if (inv_found) begin
            fill_way = inv_way;
        end else begin
            fill_way = old_way;
        end
    end

    always_comb begin
        fill_mask = '0;
        n_row     = r_rd;
        for (int w = 0; w < sacl_pkg::WAYS; w++) begin
            fill_mask[w] = (fill_way == sacl_pkg::WAY_W'(w));
            if (fill_mask[w]) begin
                n_row.tags[w] = r_tag;
                n_row.ages[w] = '0;
            end else if (cur_valid[w] && r_rd.ages[w] != AgeMax) begin
                n_row.ages[w] = r_rd.ages[w] + 1'b1;
            end
        end
    end

    assign way_ext = {2'b00, fill_way};

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_rd  <= r_mem[in_set];
            r_set <= in_set;
            r_tag <= sacl_pkg::TAG_BITS'(i_address >> sacl_pkg::INDEX_BITS);
        end
        if (i_cmd.update) begin
            r_mem[r_set] <= n_row;
            r_is_hit     <= hit;
            r_way_used   <= way_ext[sacl_pkg::WAY_OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.update) begin
            r_valid[r_set] <= cur_valid | fill_mask;
        end
    end

    assign o_is_hit   = r_is_hit;
    assign o_way_used = r_way_used;

    a_fill_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> $onehot(fill_mask))
        else $error("fill does not select exactly one way");

    a_no_dup_tags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> $onehot0(hit_vec))
        else $error("tag matched in more than one valid way");

endmodule

`default_nettype wire

>>> hdl/set_assoc_cache_lru_tags.sv
// channel   | handshake                 | payload
// ----------+---------------------------+-------------------------------
// access in | i_in_valid / o_in_ready   | i_address [31:0]
// result    | o_out_valid / i_out_ready | o_is_hit, o_way_used [1:0]
//
// an access first reads the set row from the tag memory, then does the
// compare, victim pick and row write-back through its single port
// the result word sits in an output register; the next access is taken
// while it waits, and only its write-back stalls until the slot frees
// synchronous active-low reset clears state and valid bits, no sweep

`default_nettype none

module set_assoc_cache_lru_tags (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_in_valid,
    output logic                               o_in_ready,
    input  wire  [sacl_pkg::ADDR_BITS-1:0]     i_address,
    output logic                               o_out_valid,
    input  wire                                i_out_ready,
    output logic                               o_is_hit,
    output logic [sacl_pkg::WAY_OUT_W-1:0]     o_way_used
);

    sacl_pkg::t_cmd cmd;

    sacl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    sacl_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_address  (i_address),
        .o_is_hit   (o_is_hit),
        .o_way_used (o_way_used)
    );

endmodule

`default_nettype wire
